FILE: rtl/kedf_pkg.sv
// Shared types and constants for the key debounce event queue.
`timescale 1ns / 1ps
`default_nettype none
package kedf_pkg;

  localparam int QUEUE_DEPTH_DEF = 8;
  localparam int KEY_COUNT_DEF   = 4;
  localparam int TICK_W          = 6;
  localparam int KEY_LEVEL_W     = 4;
  localparam int KEY_IDX_W       = 2;
  localparam int APB_ADDR_W      = 3;
  localparam int APB_DATA_W      = 32;

  localparam logic [TICK_W-1:0] PRESS_TICKS_RST = 6'd2;
  localparam logic [TICK_W-1:0] HOLD_TICKS_RST  = 6'd40;

  typedef enum logic [1:0] {
    KIND_PRESS   = 2'd0,
    KIND_HOLD    = 2'd1,
    KIND_RELEASE = 2'd2
  } kind_t;

  typedef enum logic {
    CMD_SCAN = 1'b0,
    CMD_POP  = 1'b1
  } cmd_t;

  typedef enum logic {
    REG_PRESS_TICKS = 1'b0,
    REG_HOLD_TICKS  = 1'b1
  } reg_idx_t;

  // Event found by one key lane on the current scan tick.
  typedef struct packed {
    logic  valid;
    kind_t kind;
  } lane_evt_t;

  // One queue entry.
  typedef struct packed {
    logic [KEY_IDX_W-1:0] key;
    kind_t                kind;
  } entry_t;

  // Outcome of one word as seen by the queue.
  typedef struct packed {
    logic                 event_valid;
    logic [KEY_IDX_W-1:0] event_key;
    kind_t                event_kind;
    logic                 queue_full;
  } pop_res_t;

endpackage
`default_nettype wire

FILE: rtl/kedf_lane.sv
// One key lane: hold counter and press, hold and release detection.
`timescale 1ns / 1ps
`default_nettype none
module kedf_lane
  import kedf_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              step_i,
  input  wire logic              pressed_i,
  input  wire logic [TICK_W-1:0] press_ticks_i,
  input  wire logic [TICK_W-1:0] hold_ticks_i,
  output lane_evt_t              evt_o
);

  logic [TICK_W-1:0] cnt_r;
  logic [TICK_W-1:0] cnt_nxt;
  logic [TICK_W:0]   inc;

  always_comb begin
    // The increment is compared one bit wider, so a wrap to 64 still holds.
    inc        = {1'b0, cnt_r} + (TICK_W+1)'(1);
    evt_o      = '{valid: 1'b0, kind: KIND_PRESS};
    cnt_nxt    = cnt_r;
    if (pressed_i) begin
      cnt_nxt = inc[TICK_W-1:0];
      if (inc < {1'b0, press_ticks_i}) begin
        evt_o.valid = 1'b0;
      end else if (inc == {1'b0, press_ticks_i}) begin
        evt_o = '{valid: 1'b1, kind: KIND_PRESS};
      end else if (inc < {1'b0, hold_ticks_i}) begin
        evt_o.valid = 1'b0;
      end else begin
        evt_o   = '{valid: 1'b1, kind: KIND_HOLD};
        cnt_nxt = '0;
      end
    end else if (cnt_r >= press_ticks_i) begin
      evt_o   = '{valid: 1'b1, kind: KIND_RELEASE};
      cnt_nxt = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else if (step_i) begin
      cnt_r <= cnt_nxt;
    end
  end

endmodule
`default_nettype wire

FILE: rtl/kedf_merge.sv
// Merge stage: orders the lane events into the ring queue and serves pops.
`timescale 1ns / 1ps
`default_nettype none
module kedf_merge
  import kedf_pkg::*;
#(
  parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF,
  parameter int KEY_COUNT   = KEY_COUNT_DEF
) (
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      scan_i,
  input  wire logic      pop_i,
  input  wire lane_evt_t evt_i [KEY_COUNT],
  output pop_res_t       res_o
);

  localparam int PTR_W  = $clog2(QUEUE_DEPTH);
  localparam int CNT_W  = $clog2(QUEUE_DEPTH + 1);
  localparam int RANK_W = $clog2(KEY_COUNT + 1);
  localparam int SUM_W  = ((CNT_W > RANK_W) ? CNT_W : RANK_W) + 1;

  entry_t            store [QUEUE_DEPTH];
  logic [PTR_W-1:0]  rp_r, rp_nxt;
  logic [PTR_W-1:0]  wp_r, wp_nxt;
  logic [CNT_W-1:0]  count_r, count_nxt;

  logic [RANK_W-1:0] rank  [KEY_COUNT];
  logic [PTR_W-1:0]  addr  [KEY_COUNT];
  logic [KEY_COUNT-1:0] acc;
  logic [RANK_W-1:0] total;
  logic [SUM_W-1:0]  free;
  logic [SUM_W-1:0]  pushed;
  logic [SUM_W-1:0]  slot_sum;
  logic [SUM_W-1:0]  wp_sum;
  logic              pop_ok;

  always_comb begin
    free  = SUM_W'(QUEUE_DEPTH) - SUM_W'(count_r);
    total = '0;
    for (int k = 0; k < KEY_COUNT; k++) begin
      total = total + RANK_W'(evt_i[k].valid);
    end
    // Each lane's slot follows the events of the lower-numbered lanes.
    for (int k = 0; k < KEY_COUNT; k++) begin
      rank[k] = '0;
      for (int j = 0; j < KEY_COUNT; j++) begin
        if (j < k) begin
          rank[k] = rank[k] + RANK_W'(evt_i[j].valid);
        end
      end
      acc[k]   = scan_i && evt_i[k].valid && (SUM_W'(rank[k]) < free);
      slot_sum = SUM_W'(wp_r) + SUM_W'(rank[k]);
      if (slot_sum >= SUM_W'(QUEUE_DEPTH)) begin
        slot_sum = slot_sum - SUM_W'(QUEUE_DEPTH);
      end
      addr[k] = slot_sum[PTR_W-1:0];
    end
    // Events beyond the free space are dropped.
    pushed = (SUM_W'(total) < free) ? SUM_W'(total) : free;
    wp_sum = SUM_W'(wp_r) + pushed;
    if (wp_sum >= SUM_W'(QUEUE_DEPTH)) begin
      wp_sum = wp_sum - SUM_W'(QUEUE_DEPTH);
    end

    pop_ok    = pop_i && (count_r != '0);
    rp_nxt    = rp_r;
    wp_nxt    = wp_r;
    count_nxt = count_r;
    if (scan_i) begin
      wp_nxt    = wp_sum[PTR_W-1:0];
      count_nxt = CNT_W'(SUM_W'(count_r) + pushed);
    end else if (pop_ok) begin
      rp_nxt    = (rp_r == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rp_r + PTR_W'(1);
      count_nxt = count_r - CNT_W'(1);
    end

    res_o.event_valid = pop_ok;
    res_o.event_key   = pop_ok ? store[rp_r].key : '0;
    res_o.event_kind  = pop_ok ? store[rp_r].kind : KIND_PRESS;
    res_o.queue_full  = (count_nxt == CNT_W'(QUEUE_DEPTH));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rp_r    <= '0;
      wp_r    <= '0;
      count_r <= '0;
    end else begin
      rp_r    <= rp_nxt;
      wp_r    <= wp_nxt;
      count_r <= count_nxt;
    end
  end

  // Accepted lanes always land on distinct slots.
  always_ff @(posedge clk) begin
    for (int e = 0; e < QUEUE_DEPTH; e++) begin
      for (int k = 0; k < KEY_COUNT; k++) begin
        if (acc[k] && (addr[k] == PTR_W'(e))) begin
          store[e] <= '{key: KEY_IDX_W'(k), kind: evt_i[k].kind};
        end
      end
    end
  end

endmodule
`default_nettype wire

FILE: rtl/key_event_debounce_fifo_top.sv
// Key debounce event queue: lanes, merge stage, output register and APB registers.
//
// Usage: every input word on the in_ channel is either a scan tick (in_cmd = 0)
// carrying the four active-low key levels, or a pop (in_cmd = 1). Each word
// yields exactly one result word on the out_ channel. A pop returns the oldest
// queued event with out_event_valid set, or out_event_valid clear when the
// queue is empty; a scan tick returns an invalid event. out_queue_full shows
// the queue state after the word.
// out_valid rises in the cycle after acceptance. Throughput is one word
// per cycle: the key lanes and the queue update together, and the output
// register takes the next word while its current word is taken in the
// same cycle. When the receiver stalls, the output register holds its word
// and in_ready drops until it is taken.
// Reset (synchronous, active low) clears the hold counters, the queue
// pointers and fill count, and loads press_ticks = 2 and hold_ticks = 40.
// The two 6-bit registers sit at byte addresses 0 and 4 of the APB port; the
// user must write them only while the block is idle; the block does not enforce it.
`timescale 1ns / 1ps
`default_nettype none
module key_event_debounce_fifo_top
  import kedf_pkg::*;
#(
  parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF,
  parameter int KEY_COUNT   = KEY_COUNT_DEF
) (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire logic                   in_valid,
  output logic                        in_ready,
  input  wire logic                   in_cmd,
  input  wire logic [KEY_LEVEL_W-1:0] in_key_levels,
  output logic                        out_valid,
  input  wire logic                   out_ready,
  output logic                        out_event_valid,
  output logic [KEY_IDX_W-1:0]        out_event_key,
  output logic [1:0]                  out_event_kind,
  output logic                        out_queue_full,
  input  wire logic                   psel,
  input  wire logic                   penable,
  input  wire logic                   pwrite,
  input  wire logic [APB_ADDR_W-1:0]  paddr,
  input  wire logic [APB_DATA_W-1:0]  pwdata,
  output logic [APB_DATA_W-1:0]       prdata,
  output logic                        pready
);

  logic [TICK_W-1:0]    press_ticks_r;
  logic [TICK_W-1:0]    hold_ticks_r;
  logic                 cfg_wr;
  reg_idx_t             cfg_idx;
  logic                 accept;
  logic                 scan;
  logic                 pop;
  logic [KEY_COUNT-1:0] pressed;
  lane_evt_t            evt [KEY_COUNT];
  pop_res_t             res;
  logic                 out_valid_r;
  pop_res_t             out_res_r;

  // Configuration port.
  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite && pready;
  assign cfg_idx = reg_idx_t'(paddr[2]);

  always_comb begin
    unique case (cfg_idx)
      REG_PRESS_TICKS: prdata = APB_DATA_W'(press_ticks_r);
      REG_HOLD_TICKS:  prdata = APB_DATA_W'(hold_ticks_r);
      default:         prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      press_ticks_r <= PRESS_TICKS_RST;
      hold_ticks_r  <= HOLD_TICKS_RST;
    end else if (cfg_wr) begin
      unique case (cfg_idx)
        REG_PRESS_TICKS: press_ticks_r <= pwdata[TICK_W-1:0];
        REG_HOLD_TICKS:  hold_ticks_r  <= pwdata[TICK_W-1:0];
        default:         press_ticks_r <= press_ticks_r;
      endcase
    end
  end

  // Input handshake.
  assign in_ready = !out_valid_r || out_ready;
  assign accept   = in_valid && in_ready;
  assign scan     = accept && (cmd_t'(in_cmd) == CMD_SCAN);
  assign pop      = accept && (cmd_t'(in_cmd) == CMD_POP);

  // Keys beyond the level bits read as pressed.
  for (genvar k = 0; k < KEY_COUNT; k++) begin : g_lane
    if (k < KEY_LEVEL_W) begin : g_lvl
      assign pressed[k] = ~in_key_levels[k];
    end else begin : g_nolvl
      assign pressed[k] = 1'b1;
    end

    kedf_lane u_lane (
      .clk          (clk),
      .rst_n        (rst_n),
      .step_i       (scan),
      .pressed_i    (pressed[k]),
      .press_ticks_i(press_ticks_r),
      .hold_ticks_i (hold_ticks_r),
      .evt_o        (evt[k])
    );
  end

  kedf_merge #(
    .QUEUE_DEPTH(QUEUE_DEPTH),
    .KEY_COUNT  (KEY_COUNT)
  ) u_merge (
    .clk   (clk),
    .rst_n (rst_n),
    .scan_i(scan),
    .pop_i (pop),
    .evt_i (evt),
    .res_o (res)
  );

  // Output register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (accept) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      out_res_r <= res;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_event_valid = out_res_r.event_valid;
  assign out_event_key   = out_res_r.event_key;
  assign out_event_kind  = out_res_r.event_kind;
  assign out_queue_full  = out_res_r.queue_full;

endmodule
`default_nettype wire

FILE: rtl/kedf_checker.sv
// Port-level checks for the key debounce event queue, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none
module kedf_checker
  import kedf_pkg::*;
(
  input wire logic                 clk,
  input wire logic                 rst_n,
  input wire logic                 in_ready,
  input wire logic                 out_valid,
  input wire logic                 out_ready,
  input wire logic                 out_event_valid,
  input wire logic [KEY_IDX_W-1:0] out_event_key,
  input wire logic [1:0]           out_event_kind,
  input wire logic                 out_queue_full
);

  // A stalled result word holds.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_event_valid)
      && $stable(out_event_key) && $stable(out_event_kind) && $stable(out_queue_full))
    else $error("stalled result word changed");

  // With the output register empty the block must take a word.
  a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid |-> in_ready)
    else $error("in_ready low with empty output register");

  // A popped event leaves at least one free slot.
  a_pop_not_full: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_event_valid |-> !out_queue_full)
    else $error("queue full right after a pop");

  // A result without an event carries zero key and kind.
  a_empty_fields: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_event_valid |-> (out_event_key == '0)
      && (out_event_kind == KIND_PRESS))
    else $error("nonzero fields on a result without an event");

  // The kind code is one of press, hold or release.
  a_kind_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_event_valid |-> (out_event_kind == KIND_PRESS)
      || (out_event_kind == KIND_HOLD) || (out_event_kind == KIND_RELEASE))
    else $error("bad event kind code");

endmodule

bind key_event_debounce_fifo_top kedf_checker u_kedf_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .in_ready       (in_ready),
  .out_valid      (out_valid),
  .out_ready      (out_ready),
  .out_event_valid(out_event_valid),
  .out_event_key  (out_event_key),
  .out_event_kind (out_event_kind),
  .out_queue_full (out_queue_full)
);
`default_nettype wire

FILE: bench/tb_key_event_debounce_fifo_top.sv
// Self-checking testbench for the key debounce event queue top level.
`timescale 1ns / 1ps
module tb_key_event_debounce_fifo_top;
  import kedf_pkg::*;

  localparam int STALL_LIMIT = 4000;
  localparam int HOLD_OFF_CYCLES = 80;
  localparam int DIR_ROWS = 24;
  localparam int N_PHASES = 9;

  typedef enum logic [1:0] {
    FILL_EMPTY = 2'd0,
    FILL_FULL  = 2'd1,
    FILL_PART  = 2'd2
  } fill_t;

  // One row of the directed table; want is used only when typed is set.
  typedef struct packed {
    cmd_t     cmd;
    logic [KEY_LEVEL_W-1:0] levels;
    logic     typed;
    pop_res_t want;
  } drow_t;

  localparam pop_res_t NO_EVENT      = '{1'b0, 2'd0, KIND_PRESS, 1'b0};
  localparam pop_res_t NO_EVENT_FULL = '{1'b0, 2'd0, KIND_PRESS, 1'b1};

  logic                   clk;
  logic                   rst_n;
  logic                   in_valid;
  logic                   in_ready;
  logic                   in_cmd;
  logic [KEY_LEVEL_W-1:0] in_key_levels;
  logic                   out_valid;
  logic                   out_ready;
  logic                   out_event_valid;
  logic [KEY_IDX_W-1:0]   out_event_key;
  logic [1:0]             out_event_kind;
  logic                   out_queue_full;
  logic                   psel;
  logic                   penable;
  logic                   pwrite;
  logic [APB_ADDR_W-1:0]  paddr;
  logic [APB_DATA_W-1:0]  pwdata;
  logic [APB_DATA_W-1:0]  prdata;
  logic                   pready;

  key_event_debounce_fifo_top u_dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_cmd         (in_cmd),
    .in_key_levels  (in_key_levels),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_event_valid(out_event_valid),
    .out_event_key  (out_event_key),
    .out_event_kind (out_event_kind),
    .out_queue_full (out_queue_full),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .prdata         (prdata),
    .pready         (pready)
  );

  // Predictor state: thresholds, per-key hold counters and the event ring.
  logic [TICK_W-1:0] press_th;
  logic [TICK_W-1:0] hold_th;
  logic [TICK_W-1:0] key_hold_cnt [KEY_COUNT_DEF];
  entry_t            event_ring [QUEUE_DEPTH_DEF];
  logic [2:0]        ring_rd;
  logic [2:0]        ring_wr;
  fill_t             ring_fill;

  pop_res_t pop_results_due [$];

  int  n_errors = 0;
  int  n_words_in = 0;
  int  n_results = 0;
  int  n_dropped = 0;
  int  n_full_seen = 0;
  int  n_settings = 1;
  int  popped_kind [3] = '{0, 0, 0};
  bit  sender_quiet = 1'b0;
  bit  receiver_quiet = 1'b0;
  bit  hold_off_req = 1'b0;
  int  idle_cycles = 0;

  drow_t dir_rows [DIR_ROWS] = '{
    '{CMD_POP,  4'hF, 1'b1, NO_EVENT},
    '{CMD_SCAN, 4'hF, 1'b1, NO_EVENT},
    '{CMD_SCAN, 4'h0, 1'b1, NO_EVENT},
    '{CMD_SCAN, 4'h0, 1'b1, NO_EVENT},
    '{CMD_SCAN, 4'h0, 1'b1, NO_EVENT},
    '{CMD_POP,  4'h0, 1'b1, '{1'b1, 2'd0, KIND_PRESS, 1'b0}},
    '{CMD_SCAN, 4'hF, 1'b1, NO_EVENT},
    '{CMD_SCAN, 4'hE, 1'b1, NO_EVENT},
    '{CMD_SCAN, 4'hE, 1'b1, NO_EVENT_FULL},
    '{CMD_SCAN, 4'hE, 1'b1, NO_EVENT_FULL},
    '{CMD_SCAN, 4'hF, 1'b1, NO_EVENT_FULL},
    '{CMD_POP,  4'hF, 1'b1, '{1'b1, 2'd1, KIND_PRESS, 1'b0}},
    '{CMD_POP,  4'hF, 1'b1, '{1'b1, 2'd2, KIND_PRESS, 1'b0}},
    '{CMD_POP,  4'hF, 1'b1, '{1'b1, 2'd3, KIND_PRESS, 1'b0}},
    '{CMD_POP,  4'hF, 1'b1, '{1'b1, 2'd0, KIND_RELEASE, 1'b0}},
    '{CMD_POP,  4'hF, 1'b1, '{1'b1, 2'd1, KIND_RELEASE, 1'b0}},
    '{CMD_POP,  4'hF, 1'b1, '{1'b1, 2'd2, KIND_RELEASE, 1'b0}},
    '{CMD_POP,  4'hF, 1'b1, '{1'b1, 2'd3, KIND_RELEASE, 1'b0}},
    '{CMD_POP,  4'hF, 1'b1, '{1'b1, 2'd0, KIND_PRESS, 1'b0}},
    '{CMD_POP,  4'h0, 1'b1, NO_EVENT},
    '{CMD_SCAN, 4'h7, 1'b0, NO_EVENT},
    '{CMD_SCAN, 4'hF, 1'b0, NO_EVENT},
    '{CMD_SCAN, 4'h7, 1'b0, NO_EVENT},
    '{CMD_POP,  4'hF, 1'b0, NO_EVENT}
  };

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  function automatic void ring_push(input logic [KEY_IDX_W-1:0] k, input kind_t kd);
    if (ring_fill == FILL_FULL) begin
      n_dropped++;
    end else begin
      event_ring[ring_wr] = '{key: k, kind: kd};
      ring_wr = ring_wr + 3'd1;
      ring_fill = (ring_wr == ring_rd) ? FILL_FULL : FILL_PART;
    end
  endfunction

  // Applies one word to the predictor state and returns the result it should give.
  function automatic pop_res_t debounce_and_pop(input cmd_t c,
                                                input logic [KEY_LEVEL_W-1:0] lv);
    pop_res_t r;
    logic [TICK_W:0] nxt;
    r = '0;
    if (c == CMD_SCAN) begin
      for (int k = 0; k < KEY_COUNT_DEF; k++) begin
        if (!lv[k]) begin
          // The count is compared one bit wider than the counter.
          nxt = {1'b0, key_hold_cnt[k]} + 1'b1;
          if (nxt == {1'b0, press_th}) begin
            ring_push(KEY_IDX_W'(k), KIND_PRESS);
          end else if (nxt > {1'b0, press_th} && nxt >= {1'b0, hold_th}) begin
            ring_push(KEY_IDX_W'(k), KIND_HOLD);
            nxt = '0;
          end
          key_hold_cnt[k] = nxt[TICK_W-1:0];
        end else if (key_hold_cnt[k] >= press_th) begin
          // A release below the press threshold leaves the counter alone.
          ring_push(KEY_IDX_W'(k), KIND_RELEASE);
          key_hold_cnt[k] = '0;
        end
      end
    end else if (ring_fill != FILL_EMPTY) begin
      r.event_valid = 1'b1;
      r.event_key   = event_ring[ring_rd].key;
      r.event_kind  = event_ring[ring_rd].kind;
      ring_rd = ring_rd + 3'd1;
      ring_fill = (ring_rd == ring_wr) ? FILL_EMPTY : FILL_PART;
    end
    r.queue_full = (ring_fill == FILL_FULL);
    return r;
  endfunction

  function automatic int pick_gap(input bit quiet);
    int r;
    r = $urandom_range(0, 99);
    if (quiet || r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  task automatic report_mismatch(input string what, input int got, input int want);
    n_errors++;
    if (n_errors <= 30)
      $display("MISMATCH %s: got %0d expected %0d at %0t", what, got, want, $time);
  endtask

  task automatic send_word(input cmd_t c, input logic [KEY_LEVEL_W-1:0] lv,
                           input logic typed, input pop_res_t want);
    pop_res_t predicted;
    int gap;
    in_valid      <= 1'b1;
    in_cmd        <= c;
    in_key_levels <= lv;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    predicted = debounce_and_pop(c, lv);
    pop_results_due.push_back(typed ? want : predicted);
    n_words_in++;
    gap = pick_gap(sender_quiet);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    while (pop_results_due.size() != 0) @(posedge clk);
  endtask

  // Leaves psel high so that a second write can follow straight away.
  task automatic cfg_write(input reg_idx_t idx, input logic [TICK_W-1:0] val);
    logic [APB_DATA_W-1:0] w;
    w = $urandom();
    w[TICK_W-1:0] = val;
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= w;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    if (idx == REG_PRESS_TICKS) press_th = val;
    else hold_th = val;
  endtask

  // Mostly runs of steady key levels with pops mixed in, some bounce and some noise.
  task automatic run_random_phase(input int n_items, input int pop_pct);
    int sent;
    int run_len;
    logic [KEY_LEVEL_W-1:0] lv;
    sent = 0;
    while (sent < n_items) begin
      if ($urandom_range(0, 99) < 75) begin
        lv = KEY_LEVEL_W'($urandom());
        run_len = $urandom_range(1, int'(press_th) + int'(hold_th) + 3);
        for (int i = 0; i < run_len && sent < n_items; i++) begin
          if ($urandom_range(0, 19) == 0)
            send_word(CMD_SCAN, lv ^ (4'b0001 << $urandom_range(0, 3)), 1'b0, '0);
          else
            send_word(CMD_SCAN, lv, 1'b0, '0);
          sent++;
          if ($urandom_range(0, 99) < pop_pct) begin
            send_word(CMD_POP, KEY_LEVEL_W'($urandom()), 1'b0, '0);
            sent++;
          end
        end
      end else begin
        send_word(cmd_t'($urandom_range(0, 1)), KEY_LEVEL_W'($urandom()), 1'b0, '0);
        sent++;
      end
    end
  endtask

  // Result side: random back-pressure plus one long hold-off on request.
  initial begin
    int rx_gap;
    rx_gap = 0;
    out_ready = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_off_req) begin
        out_ready <= 1'b0;
        repeat (HOLD_OFF_CYCLES) @(posedge clk);
        hold_off_req = 1'b0;
      end else if (rx_gap > 0) begin
        out_ready <= 1'b0;
        rx_gap--;
      end else begin
        out_ready <= 1'b1;
        if ($urandom_range(0, 2) == 0) rx_gap = pick_gap(receiver_quiet);
      end
    end
  end

  always @(posedge clk) begin
    pop_res_t want;
    if (rst_n && out_valid && out_ready) begin
      if (pop_results_due.size() == 0) begin
        report_mismatch("word with nothing expected", out_event_valid, 0);
      end else begin
        want = pop_results_due.pop_front();
        n_results++;
        if (out_event_valid !== want.event_valid)
          report_mismatch("event_valid", out_event_valid, want.event_valid);
        if (out_event_key !== want.event_key)
          report_mismatch("event_key", out_event_key, want.event_key);
        if (out_event_kind !== want.event_kind)
          report_mismatch("event_kind", out_event_kind, want.event_kind);
        if (out_queue_full !== want.queue_full)
          report_mismatch("queue_full", out_queue_full, want.queue_full);
        if (want.event_valid) popped_kind[want.event_kind]++;
        if (want.queue_full) n_full_seen++;
      end
    end
  end

  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || psel)
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= STALL_LIMIT) begin
      $display("tb_key_event_debounce_fifo_top failed");
      $finish;
    end
  end

  initial begin
    logic [TICK_W-1:0] p_press;
    logic [TICK_W-1:0] p_hold;
    int p_items;
    int p_pop;
    rst_n         = 1'b0;
    in_valid      = 1'b0;
    in_cmd        = CMD_SCAN;
    in_key_levels = '0;
    psel          = 1'b0;
    penable       = 1'b0;
    pwrite        = 1'b0;
    paddr         = '0;
    pwdata        = '0;
    press_th      = PRESS_TICKS_RST;
    hold_th       = HOLD_TICKS_RST;
    for (int k = 0; k < KEY_COUNT_DEF; k++) key_hold_cnt[k] = '0;
    for (int i = 0; i < QUEUE_DEPTH_DEF; i++) event_ring[i] = '0;
    ring_rd   = '0;
    ring_wr   = '0;
    ring_fill = FILL_EMPTY;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    for (int i = 0; i < DIR_ROWS; i++)
      send_word(dir_rows[i].cmd, dir_rows[i].levels, dir_rows[i].typed, dir_rows[i].want);

    for (int p = 0; p < N_PHASES; p++) begin
      p_items = 110;
      p_pop   = 35;
      case (p)
        0: begin p_press = 6'd2;  p_hold = 6'd40; p_items = 150; end
        1: begin p_press = 6'd1;  p_hold = 6'd2;  p_pop = 30; end
        2: begin p_press = 6'd63; p_hold = 6'd63; p_pop = 25; end
        3: begin p_press = 6'd0;  p_hold = 6'd0;  p_pop = 55; p_items = 100; end
        4: begin p_press = 6'd5;  p_hold = 6'd3;  p_pop = 40; p_items = 100; end
        5: begin p_press = 6'd3;  p_hold = 6'd8;  end
        6: begin p_press = 6'd1;  p_hold = 6'd63; p_pop = 30; end
        7: begin p_press = 6'd63; p_hold = 6'd2;  p_pop = 40; p_items = 100; end
        default: begin
          p_press = TICK_W'($urandom_range(1, 12));
          p_hold  = TICK_W'($urandom_range(2, 20));
          p_pop   = $urandom_range(20, 60);
          p_items = 130;
        end
      endcase
      if (p > 0) begin
        // Settings change only with nothing in flight.
        wait_drained();
        cfg_write(REG_PRESS_TICKS, p_press);
        cfg_write(REG_HOLD_TICKS, p_hold);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        n_settings++;
      end
      sender_quiet   = (p == 5 || p == 6);
      receiver_quiet = (p == 6);
      // The receiver stalls long while words keep coming, so the input backs up.
      if (p == 5) hold_off_req = 1'b1;
      run_random_phase(p_items, p_pop);
    end
    sender_quiet = 1'b0;
    receiver_quiet = 1'b0;

    wait_drained();
    repeat (4) @(posedge clk);
    $display("Run covered %0d words, %0d results checked, %0d register settings.",
             n_words_in, n_results, n_settings);
    $display("Popped %0d press, %0d hold, %0d release; queue full %0d times, %0d dropped.",
             popped_kind[0], popped_kind[1], popped_kind[2], n_full_seen, n_dropped);
    if (n_errors == 0)
      $display("tb_key_event_debounce_fifo_top passed");
    else
      $display("tb_key_event_debounce_fifo_top failed");
    $finish;
  end

endmodule
